### rtl/ssra_pkg.sv
`timescale 1ns / 1ps
package ssra_pkg;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 3;
  localparam int HANDLE_W = 4;
  localparam int PERIOD_W = 32;
  localparam int MASK_W   = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ENABLE = 2'd0,
    OP_PERIOD = 2'd1,
    OP_EVENT  = 2'd2,
    OP_LEAVE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_ACTIVATE   = 3'd1,
    CMD_DEACTIVATE = 3'd2,
    CMD_SET_RATE   = 3'd3,
    CMD_EVENT      = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic [HANDLE_W-1:0] target_sensor;
    logic [PERIOD_W-1:0] rate_ns;
    logic [MASK_W-1:0]   client_mask;
    logic                last;
  } res_t;

endpackage

### rtl/ssra_req_if.sv
`timescale 1ns / 1ps
interface ssra_req_if import ssra_pkg::*; ();
  logic                valid;
  logic                ready;
  op_t                 operation;
  logic [SLOT_W-1:0]   client_slot;
  logic [HANDLE_W-1:0] sensor_handle;
  logic                enable;
  logic [PERIOD_W-1:0] period_ns;

  modport source (
    output valid, operation, client_slot, sensor_handle, enable, period_ns,
    input  ready
  );
  modport sink (
    input  valid, operation, client_slot, sensor_handle, enable, period_ns,
    output ready
  );
endinterface

### rtl/ssra_res_if.sv
`timescale 1ns / 1ps
interface ssra_res_if import ssra_pkg::*; ();
  logic                valid;
  logic                ready;
  cmd_t                command;
  logic [HANDLE_W-1:0] target_sensor;
  logic [PERIOD_W-1:0] rate_ns;
  logic [MASK_W-1:0]   client_mask;
  logic                last;

  modport source (
    output valid, command, target_sensor, rate_ns, client_mask, last,
    input  ready
  );
  modport sink (
    input  valid, command, target_sensor, rate_ns, client_mask, last,
    output ready
  );
endinterface

### rtl/shared_sensor_rate_arbiter.sv
`timescale 1ns / 1ps
// enable/disable and set period read one client period per cycle through the shared
// compare; client leave takes each sensor record through a read and a write state;
// one item at a time
// reset: synchronous; a clearing pass writes zero to every address of the period and
// sensor memories, and no beat is accepted meanwhile
module shared_sensor_rate_arbiter import ssra_pkg::*; #(
  parameter int CLIENTS = 8,
  parameter int HANDLES = 16
) (
  input  logic       clk,
  input  logic       rst,
  ssra_req_if.sink   req,
  ssra_res_if.source res
);

  localparam int CW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int HW    = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam int CNW   = $clog2(CLIENTS + 1);
  localparam int PAW   = CW + HW;
  localparam int PDEPTH = 2 ** PAW;
  localparam int SW    = CLIENTS + PERIOD_W;
  localparam int HXW   = HW + HANDLE_W;
  localparam int SXW   = CW + SLOT_W;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_LOOK  = 10'b0000000100,
    S_DEC   = 10'b0000001000,
    S_ACTSR = 10'b0000010000,
    S_MIN   = 10'b0000100000,
    S_RATE  = 10'b0001000000,
    S_LV_RD = 10'b0010000000,
    S_LV_WR = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  op_t                 op_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [HANDLE_W-1:0] h_r;
  logic                en_r;
  logic [PERIOD_W-1:0] period_r;
  logic [CLIENTS-1:0]  row_r;
  logic [PERIOD_W-1:0] prog_r;
  logic [PERIOD_W-1:0] best;
  logic                found;
  logic [CNW-1:0]      ccnt;
  logic                pv;
  logic [CW-1:0]       pc;
  logic [HW-1:0]       scnt;
  logic [PAW-1:0]      clr_cnt;
  logic                pend_valid;
  res_t                pend;
  logic                o_valid;
  res_t                o;

  logic [HXW-1:0]      h_x, s_x;
  logic [SXW-1:0]      slot_x;
  logic [HW-1:0]       h_idx;
  logic [CW-1:0]       slot_idx;
  logic                slot_ok, h_ok;
  logic [CLIENTS-1:0]  slot_oh;

  logic                srec_we;
  logic [HW-1:0]       srec_waddr, srec_raddr;
  logic [SW-1:0]       srec_wdata, srec_rdata;
  logic                per_we;
  logic [PAW-1:0]      per_waddr, per_raddr;
  logic [PERIOD_W-1:0] per_wdata, per_rdata;

  logic [CLIENTS-1:0]  rrow, row_new;
  logic [PERIOD_W-1:0] rprog;
  logic [MASK_W-1:0]   ev_mask;
  logic                emit_ok, can_push, push, out_load;
  res_t                push_res, out_res;

  assign h_x      = HXW'(h_r);
  assign h_idx    = h_x[HW-1:0];
  assign s_x      = HXW'(scnt);
  assign slot_x   = SXW'(slot_r);
  assign slot_idx = slot_x[CW-1:0];
  assign slot_ok  = int'(slot_r) < CLIENTS;
  assign h_ok     = int'(h_r) < HANDLES;
  assign slot_oh  = CLIENTS'(1) << slot_idx;

  assign rrow  = srec_rdata[SW-1:PERIOD_W];
  assign rprog = srec_rdata[PERIOD_W-1:0];

  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < CLIENTS) begin : g_on
      assign ev_mask[i] = h_ok & rrow[i];
    end else begin : g_off
      assign ev_mask[i] = 1'b0;
    end
  end

  assign emit_ok  = !o_valid || res.ready;
  assign can_push = !pend_valid || emit_ok;

  ssra_ram #(.WIDTH(SW), .DEPTH(HANDLES)) u_srec (
    .clk   (clk),
    .we    (srec_we),
    .waddr (srec_waddr),
    .wdata (srec_wdata),
    .raddr (srec_raddr),
    .rdata (srec_rdata)
  );

  ssra_ram #(.WIDTH(PERIOD_W), .DEPTH(PDEPTH)) u_per (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_waddr),
    .wdata (per_wdata),
    .raddr (per_raddr),
    .rdata (per_rdata)
  );

  always_comb begin
    state_next = state;
    srec_we    = 1'b0;
    srec_waddr = h_idx;
    srec_wdata = {row_r, prog_r};
    srec_raddr = h_idx;
    per_we     = 1'b0;
    per_waddr  = {slot_idx, h_idx};
    per_wdata  = period_r;
    per_raddr  = {ccnt[CW-1:0], h_idx};
    push       = 1'b0;
    push_res   = '0;
    row_new    = rrow;
    unique case (state)
      S_CLEAR: begin
        per_we     = 1'b1;
        per_waddr  = clr_cnt;
        per_wdata  = '0;
        srec_we    = int'(clr_cnt[HW-1:0]) < HANDLES;
        srec_waddr = clr_cnt[HW-1:0];
        srec_wdata = '0;
        if (&clr_cnt) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        priority if (op_r == OP_EVENT) begin
          state_next = S_DEC;
        end else if (op_r == OP_LEAVE) begin
          state_next = slot_ok ? S_LV_RD : S_FIN;
        end else begin
          state_next = (slot_ok && h_ok) ? S_DEC : S_FIN;
        end
      end
      S_DEC: begin
        unique case (op_r)
          OP_EVENT: begin
            push     = 1'b1;
            push_res = '{command: CMD_EVENT, target_sensor: h_r, rate_ns: '0,
                         client_mask: ev_mask, last: 1'b0};
            state_next = S_FIN;
          end
          OP_PERIOD: begin
            per_we     = 1'b1;
            state_next = S_MIN;
          end
          OP_ENABLE: begin
            state_next = S_MIN;
            if (en_r && !rrow[slot_idx]) begin
              row_new    = rrow | slot_oh;
              srec_we    = 1'b1;
              srec_wdata = {row_new, rprog};
              if (rrow == '0) begin
                push     = 1'b1;
                push_res = '{command: CMD_ACTIVATE, target_sensor: h_r, rate_ns: '0,
                             client_mask: '0, last: 1'b0};
                if (rprog != '0) begin
                  state_next = S_ACTSR;
                end
              end
            end else if (!en_r && rrow[slot_idx]) begin
              row_new    = rrow & ~slot_oh;
              srec_we    = 1'b1;
              srec_wdata = {row_new, rprog};
              if (row_new == '0) begin
                push     = 1'b1;
                push_res = '{command: CMD_DEACTIVATE, target_sensor: h_r, rate_ns: '0,
                             client_mask: '0, last: 1'b0};
              end
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_ACTSR: begin
        if (can_push) begin
          push     = 1'b1;
          push_res = '{command: CMD_SET_RATE, target_sensor: h_r, rate_ns: prog_r,
                       client_mask: '0, last: 1'b0};
          state_next = S_MIN;
        end
      end
      S_MIN: begin
        if (int'(ccnt) == CLIENTS && !pv) begin
          state_next = S_RATE;
        end
      end
      S_RATE: begin
        if (found && best != prog_r) begin
          if (can_push) begin
            push       = 1'b1;
            push_res   = '{command: CMD_SET_RATE, target_sensor: h_r, rate_ns: best,
                           client_mask: '0, last: 1'b0};
            srec_we    = 1'b1;
            srec_wdata = {row_r, best};
            state_next = S_FIN;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_LV_RD: begin
        srec_raddr = scnt;
        per_we     = 1'b1;
        per_waddr  = {slot_idx, scnt};
        per_wdata  = '0;
        state_next = S_LV_WR;
      end
      S_LV_WR: begin
        srec_raddr = scnt;
        srec_waddr = scnt;
        srec_wdata = {rrow, rprog};
        if (rrow[slot_idx]) begin
          row_new    = rrow & ~slot_oh;
          srec_wdata = {row_new, rprog};
        end
        if (!(rrow[slot_idx] && row_new == '0 && !can_push)) begin
          srec_we = rrow[slot_idx];
          if (rrow[slot_idx] && row_new == '0) begin
            push     = 1'b1;
            push_res = '{command: CMD_DEACTIVATE, target_sensor: s_x[HANDLE_W-1:0],
                         rate_ns: '0, client_mask: '0, last: 1'b0};
          end
          state_next = (int'(scnt) == HANDLES - 1) ? S_FIN : S_LV_RD;
        end
      end
      S_FIN: begin
        if (emit_ok) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_load = 1'b0;
    out_res  = pend;
    if (state == S_FIN) begin
      out_load = emit_ok;
      if (pend_valid) begin
        out_res.last = 1'b1;
      end else begin
        out_res = '{command: CMD_NONE, target_sensor: '0, rate_ns: '0,
                    client_mask: '0, last: 1'b1};
      end
    end else if (push && pend_valid) begin
      out_load     = 1'b1;
      out_res.last = 1'b0;
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
      ccnt       <= '0;
      pv         <= 1'b0;
      found      <= 1'b0;
      scnt       <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + PAW'(1);
      end
      if (req.valid && req.ready) begin
        op_r     <= req.operation;
        slot_r   <= req.client_slot;
        h_r      <= req.sensor_handle;
        en_r     <= req.enable;
        period_r <= req.period_ns;
        scnt     <= '0;
      end
      if (state == S_DEC) begin
        row_r  <= row_new;
        prog_r <= rprog;
        ccnt   <= '0;
        pv     <= 1'b0;
        found  <= 1'b0;
      end
      if (state == S_MIN) begin
        if (int'(ccnt) < CLIENTS) begin
          ccnt <= ccnt + CNW'(1);
          pv   <= 1'b1;
          pc   <= ccnt[CW-1:0];
        end else begin
          pv <= 1'b0;
        end
        if (pv && row_r[pc] && per_rdata != '0 && (!found || per_rdata < best)) begin
          best  <= per_rdata;
          found <= 1'b1;
        end
      end
      if (state == S_LV_WR && state_next == S_LV_RD) begin
        scnt <= scnt + HW'(1);
      end
      if (push) begin
        pend_valid <= 1'b1;
        pend       <= push_res;
      end else if (state == S_FIN && emit_ok) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        o_valid <= 1'b1;
        o       <= out_res;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign res.valid         = o_valid;
  assign res.command       = o.command;
  assign res.target_sensor = o.target_sensor;
  assign res.rate_ns       = o.rate_ns;
  assign res.client_mask   = o.client_mask;
  assign res.last          = o.last;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("new beat taken while an item is in progress");

  a_pend_empty_at_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_LOOK || state == S_DEC) |-> !pend_valid)
    else $error("held result left over from an earlier item");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.command == CMD_NONE || res.command == CMD_EVENT) |-> res.last)
    else $error("none or event beat without last");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    out_load && out_res.last |=> state == S_IDLE)
    else $error("final beat issued while the sequencer keeps running");

endmodule

### rtl/ssra_ram.sv
`timescale 1ns / 1ps
module ssra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### test/shared_sensor_rate_arbiter_test.sv
`timescale 1ns / 1ps
module shared_sensor_rate_arbiter_test import ssra_pkg::*; ();

  localparam int NUM_CLIENTS  = 8;
  localparam int NUM_SENSORS  = 16;
  localparam int RANDOM_REQS  = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 50;

  typedef struct {
    op_t                 op;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                en;
    logic [PERIOD_W-1:0] period;
    bit                  drain;
  } sensor_req_t;

  logic clk = 1'b0;
  logic rst;

  ssra_req_if req ();
  ssra_res_if res ();

  shared_sensor_rate_arbiter dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the arbiter state
  bit                  sub_bits  [NUM_CLIENTS][NUM_SENSORS];
  logic [PERIOD_W-1:0] req_period[NUM_CLIENTS][NUM_SENSORS];
  int                  sub_count [NUM_SENSORS];
  logic [PERIOD_W-1:0] hw_period [NUM_SENSORS];

  sensor_req_t pending[$];
  res_t        sensor_cmds[$];
  int          errors      = 0;
  int          pushed_cnt  = 0;
  int          checked_cnt = 0;
  int          send_gap;
  int          sink_gap;
  int          hold_left;
  int          cycle_cnt   = 0;
  int          idle_cycles = 0;

  function automatic void add_cmd(cmd_t cmd, logic [HANDLE_W-1:0] sensor,
                                  logic [PERIOD_W-1:0] rate, logic [MASK_W-1:0] mask);
    res_t r;
    r.command       = cmd;
    r.target_sensor = sensor;
    r.rate_ns       = rate;
    r.client_mask   = mask;
    r.last          = 1'b0;
    sensor_cmds.push_back(r);
  endfunction

  function automatic void retune(int h);
    logic [PERIOD_W-1:0] best;
    bit                  found;
    best  = '0;
    found = 1'b0;
    for (int c = 0; c < NUM_CLIENTS; c++) begin
      if (sub_bits[c][h] && req_period[c][h] != 0 && (!found || req_period[c][h] < best)) begin
        best  = req_period[c][h];
        found = 1'b1;
      end
    end
    if (found && (hw_period[h] == 0 || hw_period[h] != best)) begin
      hw_period[h] = best;
      add_cmd(CMD_SET_RATE, HANDLE_W'(h), best, '0);
    end
  endfunction

  function automatic void arbitrate(sensor_req_t it);
    int                start;
    int                c;
    int                h;
    logic [MASK_W-1:0] mask;
    start = sensor_cmds.size();
    c     = int'(it.slot);
    h     = int'(it.handle);
    mask  = '0;
    case (it.op)
      OP_ENABLE: begin
        if (it.en && !sub_bits[c][h]) begin
          sub_bits[c][h] = 1'b1;
          if (sub_count[h] == 0) begin
            add_cmd(CMD_ACTIVATE, HANDLE_W'(h), '0, '0);
            if (hw_period[h] != 0) add_cmd(CMD_SET_RATE, HANDLE_W'(h), hw_period[h], '0);
          end
          sub_count[h]++;
        end else if (!it.en && sub_bits[c][h]) begin
          sub_bits[c][h] = 1'b0;
          if (sub_count[h] > 0) sub_count[h]--;
          if (sub_count[h] == 0) add_cmd(CMD_DEACTIVATE, HANDLE_W'(h), '0, '0);
        end
        retune(h);
      end
      OP_PERIOD: begin
        req_period[c][h] = it.period;
        retune(h);
      end
      OP_EVENT: begin
        for (int k = 0; k < NUM_CLIENTS; k++) mask[k] = sub_bits[k][h];
        add_cmd(CMD_EVENT, HANDLE_W'(h), '0, mask);
      end
      OP_LEAVE: begin
        for (int s = 0; s < NUM_SENSORS; s++) begin
          if (sub_bits[c][s]) begin
            sub_bits[c][s] = 1'b0;
            if (sub_count[s] > 0) sub_count[s]--;
            if (sub_count[s] == 0) add_cmd(CMD_DEACTIVATE, HANDLE_W'(s), '0, '0);
          end
          req_period[c][s] = '0;
        end
      end
      default: ;
    endcase
    if (sensor_cmds.size() == start) add_cmd(CMD_NONE, '0, '0, '0);
    sensor_cmds[sensor_cmds.size()-1].last = 1'b1;
    pushed_cnt += sensor_cmds.size() - start;
  endfunction

  function automatic void queue_request(op_t op, int slot, int handle, int en,
                                        logic [PERIOD_W-1:0] period, bit drain = 1'b0);
    sensor_req_t it;
    it.op     = op;
    it.slot   = SLOT_W'(slot);
    it.handle = HANDLE_W'(handle);
    it.en     = (en != 0);
    it.period = period;
    it.drain  = drain;
    pending.push_back(it);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (cycle_cnt % 512 < 96) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid         <= 1'b0;
      req.operation     <= OP_ENABLE;
      req.client_slot   <= '0;
      req.sensor_handle <= '0;
      req.enable        <= 1'b0;
      req.period_ns     <= '0;
      send_gap = 0;
    end else begin
      if (req.valid && req.ready) begin
        arbitrate(pending.pop_front());
        send_gap = pick_gap();
      end
      if (req.valid && !req.ready) begin
        // beat still offered
      end else if (send_gap > 0) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (pending.size() != 0 && (!pending[0].drain || pushed_cnt == checked_cnt)) begin
        req.valid         <= 1'b1;
        req.operation     <= pending[0].op;
        req.client_slot   <= pending[0].slot;
        req.sensor_handle <= pending[0].handle;
        req.enable        <= pending[0].en;
        req.period_ns     <= pending[0].period;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res.ready <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (sensor_cmds.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual cmd %0d sensor %0h",
                   $time, res.command, res.target_sensor);
          errors++;
        end else begin
          want = sensor_cmds.pop_front();
          check_field("command", 32'(want.command), 32'(res.command));
          check_field("target_sensor", 32'(want.target_sensor), 32'(res.target_sensor));
          check_field("rate_ns", want.rate_ns, res.rate_ns);
          check_field("client_mask", 32'(want.client_mask), 32'(res.client_mask));
          check_field("last", 32'(want.last), 32'(res.last));
          checked_cnt <= checked_cnt + 1;
        end
        // long back-pressure so the request side stalls
        if (checked_cnt == 60 || checked_cnt == 250) hold_left = HOLD_CYCLES;
        else sink_gap = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                  r;
    op_t                 op;
    int                  h;
    logic [PERIOD_W-1:0] p;

    rst = 1'b1;

    // directed
    queue_request(OP_EVENT, 0, 0, 0, 0);
    queue_request(OP_ENABLE, 0, 0, 0, 0);
    queue_request(OP_PERIOD, 0, 15, 0, 32'hFFFF_FFFF);
    queue_request(OP_ENABLE, 0, 15, 1, 0);
    queue_request(OP_ENABLE, 0, 15, 1, 0);
    queue_request(OP_ENABLE, 7, 15, 1, 0);
    queue_request(OP_PERIOD, 7, 15, 0, 32'd1);
    queue_request(OP_PERIOD, 7, 15, 0, 32'd0);
    queue_request(OP_EVENT, 0, 15, 0, 0);
    queue_request(OP_ENABLE, 0, 15, 0, 0);
    queue_request(OP_ENABLE, 7, 15, 0, 0);
    queue_request(OP_ENABLE, 3, 15, 1, 0);
    queue_request(OP_PERIOD, 3, 15, 0, 32'hAAAA_AAAA);
    queue_request(OP_PERIOD, 3, 15, 0, 32'h5555_5555);
    queue_request(OP_ENABLE, 2, 0, 1, 0);
    queue_request(OP_ENABLE, 2, 8, 1, 0);
    queue_request(OP_PERIOD, 2, 8, 0, 32'd500);
    queue_request(OP_ENABLE, 5, 8, 1, 0);
    queue_request(OP_PERIOD, 5, 8, 0, 32'd700);
    queue_request(OP_LEAVE, 2, 0, 0, 0);
    queue_request(OP_EVENT, 0, 8, 0, 0);
    queue_request(OP_LEAVE, 3, 0, 0, 0);
    queue_request(OP_LEAVE, 6, 0, 0, 0);
    queue_request(OP_ENABLE, 3, 15, 1, 0, 1'b1);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_ENABLE;
      else if (r < 70) op = OP_PERIOD;
      else if (r < 90) op = OP_EVENT;
      else op = OP_LEAVE;
      h = ($urandom_range(0, 3) < 3) ? $urandom_range(0, 3) : $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0:       p = '0;
        1:       p = 32'hFFFF_FFFF;
        2, 3:    p = $urandom;
        default: p = $urandom_range(1, 1000);
      endcase
      queue_request(op, $urandom_range(0, 7), h, int'($urandom_range(0, 9) < 6), p,
                    i == 150 || $urandom_range(0, 99) == 0);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || sensor_cmds.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
